>>> hdl/wbs_pkg.sv
package wbs_pkg;

	localparam logic [15:0] THR_RESET = 16'd19661;
	localparam int MUL_W = 20;
	localparam int COORD_CNT = 8;
	localparam int QUOT_W = 16;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic signed [15:0] right;
		logic signed [15:0] bottom;
		logic        [15:0] score;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] bx;
		logic signed [15:0] by;
	} det_t;

	// edges first, then keypoints
	function automatic logic signed [15:0] det_coord(det_t d, logic [2:0] k);
		logic signed [15:0] v;
		case (k)
			3'd0: v = d.left;
			3'd1: v = d.top;
			3'd2: v = d.right;
			3'd3: v = d.bottom;
			3'd4: v = d.ax;
			3'd5: v = d.ay;
			3'd6: v = d.bx;
			default: v = d.by;
		endcase
		return v;
	endfunction

endpackage

>>> hdl/wbs_store.sv
module wbs_store import wbs_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  det_t          wdata,
	input  logic [AW-1:0] raddr,
	output det_t          rdata
);

	det_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/wbs_mul.sv
module wbs_mul import wbs_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  a,
	input  logic signed [MUL_W-1:0]  b,
	output logic signed [2*MUL_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

>>> hdl/wbs_div.sv
module wbs_div import wbs_pkg::*; #(
	parameter int SW = 39,
	parameter int TW = 23
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [SW-1:0]     num,
	input  logic        [TW-1:0]     den,
	output logic                     done_q,
	output logic signed [QUOT_W-1:0] quot
);

	logic              running_q;
	logic [3:0]        step_q;
	logic              neg_q;
	logic [SW:0]       rem_q;
	logic [SW:0]       dsh_q;
	logic [QUOT_W-1:0] q_q;
	logic signed [SW:0] numx;
	logic signed [SW:0] absv;
	logic [SW:0]       mag;
	logic              fits;

	// round half away from zero: add half the divisor to the magnitude
	assign numx = (SW+1)'(num);
	assign absv = (numx < 0) ? -numx : numx;
	assign mag = $unsigned(absv) + (SW+1)'(den >> 1);
	assign fits = (rem_q >= dsh_q);
	assign quot = neg_q ? -$signed(q_q) : $signed(q_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
				step_q <= 4'd15;
			end else if (running_q) begin
				step_q <= step_q - 4'd1;
				if (step_q == 4'd0) begin
					running_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= mag;
			dsh_q <= (SW+1)'(den) << (QUOT_W - 1);
			neg_q <= num[SW-1];
			q_q <= '0;
		end else if (running_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q <= dsh_q >> 1;
			q_q <= {q_q[QUOT_W-2:0], fits};
		end
	end

endmodule

>>> hdl/weighted_box_suppression.sv
// Weighted box suppression over one set of detections.
// Detections arrive on the request channel: a request is taken at a clock
// edge where start is high and busy is low, one detection per cycle while
// the set loads. Up to MAX_DETECTIONS are kept; later ones are dropped, but
// set_end on a dropped request still closes the set. The request carrying
// set_end raises busy and starts processing; busy stays high until the last
// result of the set has been sent.
// Each round scans the set for the best remaining detection, then walks
// the set again with one shared 20x20 multiplier, testing each overlapping
// entry against the threshold and summing the weighted coordinates of each
// merged one. A merged result then runs 8 divisions on the shared divider.
// Each result is shown for one cycle with done high; final_result marks the
// last one of the set. The receiver cannot stall, so results are never held.
// The overlap threshold is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while idle, as the block itself does not enforce this.
// Reset clears the set, the controller and sets the threshold to 0.3.
module weighted_box_suppression import wbs_pkg::*; #(
	parameter int MAX_DETECTIONS = 64,
	parameter int KEYPOINT_CNT = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] box_left,
	input  logic signed [15:0] box_top,
	input  logic signed [15:0] box_right,
	input  logic signed [15:0] box_bottom,
	input  logic        [15:0] det_score,
	input  logic signed [15:0] point_a_x,
	input  logic signed [15:0] point_a_y,
	input  logic signed [15:0] point_b_x,
	input  logic signed [15:0] point_b_y,
	input  logic               set_end,
	input  logic               cfg_wr_en,
	input  logic        [15:0] cfg_wr_data,
	output logic               done,
	output logic signed [15:0] out_left,
	output logic signed [15:0] out_top,
	output logic signed [15:0] out_right,
	output logic signed [15:0] out_bottom,
	output logic        [15:0] out_score,
	output logic signed [15:0] out_point_a_x,
	output logic signed [15:0] out_point_a_y,
	output logic signed [15:0] out_point_b_x,
	output logic signed [15:0] out_point_b_y,
	output logic               final_result
);

	localparam int IW = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
	localparam int CW = $clog2(MAX_DETECTIONS + 1);
	localparam int KPC = (KEYPOINT_CNT < 2) ? 2 * KEYPOINT_CNT : 4;
	localparam int SW = 32 + CW;
	localparam int TW = 16 + CW;
	localparam int PW = 2 * MUL_W;
	localparam int CMPW = 64;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_DETECTIONS);

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_F_RD    = 5'd1;
	localparam logic [4:0] S_F_CHK   = 5'd2;
	localparam logic [4:0] S_T_AREA  = 5'd3;
	localparam logic [4:0] S_T_AREA2 = 5'd4;
	localparam logic [4:0] S_C_RD    = 5'd5;
	localparam logic [4:0] S_C_CHK   = 5'd6;
	localparam logic [4:0] S_C_M1    = 5'd7;
	localparam logic [4:0] S_C_M2    = 5'd8;
	localparam logic [4:0] S_C_M3    = 5'd9;
	localparam logic [4:0] S_C_M4    = 5'd10;
	localparam logic [4:0] S_C_M5    = 5'd11;
	localparam logic [4:0] S_C_M6    = 5'd12;
	localparam logic [4:0] S_C_W     = 5'd13;
	localparam logic [4:0] S_C_DONE  = 5'd14;
	localparam logic [4:0] S_DV_GO   = 5'd15;
	localparam logic [4:0] S_DV_WT   = 5'd16;
	localparam logic [4:0] S_EMIT    = 5'd17;

	logic [4:0]  state_q;
	logic [15:0] thr_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] p_q;
	logic [MAX_DETECTIONS-1:0] rem_q;
	logic        found_q;
	logic        any_rm_q;
	logic [TW-1:0] total_q;
	logic [3:0]  wk_q;
	logic [2:0]  k_q;
	det_t        top_q;
	logic signed [PW-1:0] area_t_q;
	logic signed [PW-1:0] inter_q;
	logic signed [PW:0]   union_q;
	logic signed [PW-1:0] hi_q;
	logic signed [16:0]   dx_q;
	logic signed [16:0]   dy_q;
	logic signed [SW-1:0] sum_q [COORD_CNT];
	logic signed [15:0]   res_q [COORD_CNT];

	logic        done_q;
	logic        final_q;
	det_t        out_q;

	det_t        wdata;
	det_t        rd;
	logic        accept;
	logic        we;
	logic [CW-1:0] n_new;
	logic [CW-1:0] p_nx;
	logic        p_last;

	logic signed [MUL_W-1:0] ma;
	logic signed [MUL_W-1:0] mb;
	logic signed [PW-1:0]    prod;

	logic        div_start;
	logic        div_done;
	logic signed [QUOT_W-1:0] div_q;

	logic signed [15:0] il, it, ir, ib;
	logic        no_ov;
	logic signed [PW:0] uni;
	logic signed [CMPW-1:0] lhs, rhs;
	logic [2:0]  wi;
	logic        fin;

	assign accept = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);
	assign we = accept && (cnt_q < MAX_CNT);
	assign n_new = cnt_q + ((cnt_q < MAX_CNT) ? CW'(1) : CW'(0));
	assign p_nx = p_q + CW'(1);
	assign p_last = (p_nx == n_q);

	always_comb begin
		wdata.left = box_left;
		wdata.top = box_top;
		wdata.right = box_right;
		wdata.bottom = box_bottom;
		wdata.score = det_score;
		wdata.ax = (KPC > 0) ? point_a_x : 16'sd0;
		wdata.ay = (KPC > 0) ? point_a_y : 16'sd0;
		wdata.bx = (KPC > 2) ? point_b_x : 16'sd0;
		wdata.by = (KPC > 2) ? point_b_y : 16'sd0;
	end

	wbs_store #(
		.DEPTH(MAX_DETECTIONS),
		.AW(IW)
	) u_store (
		.clk(clk),
		.we(we),
		.waddr(cnt_q[IW-1:0]),
		.wdata(wdata),
		.raddr(p_q[IW-1:0]),
		.rdata(rd)
	);

	wbs_mul u_mul (
		.clk(clk),
		.a(ma),
		.b(mb),
		.p_q(prod)
	);

	wbs_div #(
		.SW(SW),
		.TW(TW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(sum_q[k_q]),
		.den(total_q),
		.done_q(div_done),
		.quot(div_q)
	);

	// intersection of the top box with the entry under test
	assign il = (top_q.left > rd.left) ? top_q.left : rd.left;
	assign it = (top_q.top > rd.top) ? top_q.top : rd.top;
	assign ir = (top_q.right < rd.right) ? top_q.right : rd.right;
	assign ib = (top_q.bottom < rd.bottom) ? top_q.bottom : rd.bottom;
	assign no_ov = (il > ir) || (it > ib);
	assign uni = (PW+1)'(area_t_q) + (PW+1)'(prod) - (PW+1)'(inter_q);
	assign lhs = CMPW'(inter_q) <<< 16;
	assign rhs = (CMPW'(hi_q) <<< 18) + CMPW'(prod);
	assign wi = 3'(wk_q - 4'd1);
	assign fin = !any_rm_q || (rem_q == '0);
	assign div_start = (state_q == S_DV_GO);

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			S_T_AREA: begin
				ma = MUL_W'(17'(top_q.right) - 17'(top_q.left));
				mb = MUL_W'(17'(top_q.bottom) - 17'(top_q.top));
			end
			S_C_M1: begin
				ma = MUL_W'(dx_q);
				mb = MUL_W'(dy_q);
			end
			S_C_M2: begin
				ma = MUL_W'(17'(rd.right) - 17'(rd.left));
				mb = MUL_W'(17'(rd.bottom) - 17'(rd.top));
			end
			S_C_M4: begin
				ma = MUL_W'(thr_q);
				mb = MUL_W'(union_q >>> 18);
			end
			S_C_M5: begin
				ma = MUL_W'(thr_q);
				mb = MUL_W'(union_q[17:0]);
			end
			S_C_W: begin
				if (wk_q < 4'd8) begin
					ma = MUL_W'(det_coord(rd, wk_q[2:0]));
					mb = MUL_W'(rd.score);
				end
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			thr_q <= THR_RESET;
			cnt_q <= '0;
			n_q <= '0;
			p_q <= '0;
			rem_q <= '0;
			found_q <= 1'b0;
			any_rm_q <= 1'b0;
			total_q <= '0;
			wk_q <= '0;
			k_q <= '0;
			done_q <= 1'b0;
			final_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= n_new;
						if (set_end) begin
							n_q <= n_new;
							for (int i = 0; i < MAX_DETECTIONS; i++) begin
								rem_q[i] <= (CW'(i) < n_new);
							end
							p_q <= '0;
							found_q <= 1'b0;
							any_rm_q <= 1'b0;
							total_q <= '0;
							state_q <= S_F_RD;
						end
					end
				end
				S_F_RD: begin
					state_q <= S_F_CHK;
				end
				S_F_CHK: begin
					// strict compare keeps the earliest entry on equal scores
					if (rem_q[p_q[IW-1:0]] && (!found_q || rd.score > top_q.score)) begin
						found_q <= 1'b1;
					end
					if (p_last) begin
						p_q <= '0;
						state_q <= (found_q || rem_q[p_q[IW-1:0]]) ? S_T_AREA : S_IDLE;
						if (!(found_q || rem_q[p_q[IW-1:0]])) begin
							cnt_q <= '0;
						end
					end else begin
						p_q <= p_nx;
						state_q <= S_F_RD;
					end
				end
				S_T_AREA: begin
					state_q <= S_T_AREA2;
				end
				S_T_AREA2: begin
					state_q <= S_C_RD;
				end
				S_C_RD: begin
					state_q <= S_C_CHK;
				end
				S_C_CHK: begin
					if (rem_q[p_q[IW-1:0]] && !no_ov) begin
						state_q <= S_C_M1;
					end else if (p_last) begin
						state_q <= S_C_DONE;
					end else begin
						p_q <= p_nx;
						state_q <= S_C_RD;
					end
				end
				S_C_M1: begin
					state_q <= S_C_M2;
				end
				S_C_M2: begin
					state_q <= S_C_M3;
				end
				S_C_M3: begin
					if (uni <= 0) begin
						if (p_last) begin
							state_q <= S_C_DONE;
						end else begin
							p_q <= p_nx;
							state_q <= S_C_RD;
						end
					end else begin
						state_q <= S_C_M4;
					end
				end
				S_C_M4: begin
					state_q <= S_C_M5;
				end
				S_C_M5: begin
					state_q <= S_C_M6;
				end
				S_C_M6: begin
					if (lhs > rhs) begin
						rem_q[p_q[IW-1:0]] <= 1'b0;
						any_rm_q <= 1'b1;
						total_q <= total_q + TW'(rd.score);
						wk_q <= '0;
						state_q <= S_C_W;
					end else if (p_last) begin
						state_q <= S_C_DONE;
					end else begin
						p_q <= p_nx;
						state_q <= S_C_RD;
					end
				end
				S_C_W: begin
					wk_q <= wk_q + 4'd1;
					if (wk_q == 4'd8) begin
						if (p_last) begin
							state_q <= S_C_DONE;
						end else begin
							p_q <= p_nx;
							state_q <= S_C_RD;
						end
					end
				end
				S_C_DONE: begin
					k_q <= '0;
					state_q <= (!any_rm_q || total_q == '0) ? S_EMIT : S_DV_GO;
				end
				S_DV_GO: begin
					state_q <= S_DV_WT;
				end
				S_DV_WT: begin
					if (div_done) begin
						k_q <= k_q + 3'd1;
						state_q <= (k_q == 3'(COORD_CNT - 1)) ? S_EMIT : S_DV_GO;
					end
				end
				S_EMIT: begin
					done_q <= 1'b1;
					final_q <= fin;
					p_q <= '0;
					found_q <= 1'b0;
					any_rm_q <= 1'b0;
					total_q <= '0;
					if (fin) begin
						cnt_q <= '0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_F_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_F_CHK && rem_q[p_q[IW-1:0]] &&
				(!found_q || rd.score > top_q.score)) begin
			top_q <= rd;
		end
		if (state_q == S_T_AREA2) begin
			area_t_q <= prod;
		end
		if (state_q == S_C_CHK) begin
			dx_q <= 17'(ir) - 17'(il);
			dy_q <= 17'(ib) - 17'(it);
		end
		if (state_q == S_C_M2) begin
			inter_q <= prod;
		end
		if (state_q == S_C_M3) begin
			union_q <= uni;
		end
		if (state_q == S_C_M5) begin
			hi_q <= prod;
		end
		if (state_q == S_C_W && wk_q != 4'd0) begin
			sum_q[wi] <= sum_q[wi] + SW'(prod);
		end
		if ((state_q == S_IDLE && accept && set_end) || state_q == S_EMIT) begin
			for (int c = 0; c < COORD_CNT; c++) begin
				sum_q[c] <= '0;
			end
		end
		if (state_q == S_C_DONE) begin
			for (int c = 0; c < COORD_CNT; c++) begin
				res_q[c] <= det_coord(top_q, 3'(c));
			end
		end
		if (state_q == S_DV_WT && div_done) begin
			res_q[k_q] <= div_q;
		end
		if (state_q == S_EMIT) begin
			out_q.left <= res_q[0];
			out_q.top <= res_q[1];
			out_q.right <= res_q[2];
			out_q.bottom <= res_q[3];
			out_q.score <= top_q.score;
			out_q.ax <= res_q[4];
			out_q.ay <= res_q[5];
			out_q.bx <= res_q[6];
			out_q.by <= res_q[7];
		end
	end

	assign done = done_q;
	assign final_result = final_q;
	assign out_left = out_q.left;
	assign out_top = out_q.top;
	assign out_right = out_q.right;
	assign out_bottom = out_q.bottom;
	assign out_score = out_q.score;
	assign out_point_a_x = out_q.ax;
	assign out_point_a_y = out_q.ay;
	assign out_point_b_x = out_q.bx;
	assign out_point_b_y = out_q.by;

endmodule

>>> tb/testbench.sv
module testbench;
	import wbs_pkg::*;

	typedef struct {
		det_t d;
		logic last;
	} request_t;

	typedef struct {
		det_t d;
		logic fin;
	} merged_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	det_t               bus;
	logic               set_end;
	logic               cfg_wr_en;
	logic        [15:0] cfg_wr_data;
	logic               done;
	det_t               seen;
	logic               final_result;

	request_t pending[$];
	request_t staged;
	merged_t  expected[$];
	int       idle_pct;
	int       mismatches = 0;

	// predictor state
	logic [15:0] thr;
	det_t        held[64];
	int          loaded = 0;

	weighted_box_suppression dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.box_left(bus.left), .box_top(bus.top), .box_right(bus.right),
		.box_bottom(bus.bottom), .det_score(bus.score),
		.point_a_x(bus.ax), .point_a_y(bus.ay), .point_b_x(bus.bx), .point_b_y(bus.by),
		.set_end(set_end), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.done(done), .out_left(seen.left), .out_top(seen.top), .out_right(seen.right),
		.out_bottom(seen.bottom), .out_score(seen.score),
		.out_point_a_x(seen.ax), .out_point_a_y(seen.ay),
		.out_point_b_x(seen.bx), .out_point_b_y(seen.by),
		.final_result(final_result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit boxes_overlap(det_t a, det_t b);
		longint l, t, r, btm, inter, ua;
		l = longint'((a.left > b.left) ? a.left : b.left);
		t = longint'((a.top > b.top) ? a.top : b.top);
		r = longint'((a.right < b.right) ? a.right : b.right);
		btm = longint'((a.bottom < b.bottom) ? a.bottom : b.bottom);
		if (l > r || t > btm)
			return 0;
		inter = (r - l) * (btm - t);
		ua = (longint'(a.right) - longint'(a.left)) * (longint'(a.bottom) - longint'(a.top))
			+ (longint'(b.right) - longint'(b.left)) * (longint'(b.bottom) - longint'(b.top))
			- inter;
		if (ua <= 0)
			return 0;
		return inter * 65536 > longint'(thr) * ua;
	endfunction

	function automatic logic [15:0] nearest_div(longint num, longint den);
		longint q;
		if (num >= 0)
			q = (num + den / 2) / den;
		else
			q = -((-num + den / 2) / den);
		return q[15:0];
	endfunction

	// order by score, then peel off clusters until one stands alone
	task automatic merge_set();
		int     ord[64];
		bit     alive[64];
		int     j, top, removed, emitted;
		longint sums[8];
		longint total;
		longint sc;
		det_t   dd, res;
		merged_t m;
		emitted = 0;
		for (int i = 0; i < loaded; i++) begin
			j = i;
			while (j > 0 && held[ord[j - 1]].score < held[i].score) begin
				ord[j] = ord[j - 1];
				j--;
			end
			ord[j] = i;
			alive[i] = 1;
		end
		while (emitted < 64) begin
			top = -1;
			for (int p = 0; p < loaded; p++)
				if (top < 0 && alive[ord[p]])
					top = ord[p];
			if (top < 0)
				break;
			removed = 0;
			total = 0;
			for (int c = 0; c < 8; c++)
				sums[c] = 0;
			for (int p = 0; p < loaded; p++) begin
				dd = held[ord[p]];
				if (alive[ord[p]] && boxes_overlap(dd, held[top])) begin
					alive[ord[p]] = 0;
					removed++;
					sc = longint'(dd.score);
					total += sc;
					sums[0] += longint'(dd.left) * sc;
					sums[1] += longint'(dd.top) * sc;
					sums[2] += longint'(dd.right) * sc;
					sums[3] += longint'(dd.bottom) * sc;
					sums[4] += longint'(dd.ax) * sc;
					sums[5] += longint'(dd.ay) * sc;
					sums[6] += longint'(dd.bx) * sc;
					sums[7] += longint'(dd.by) * sc;
				end
			end
			res = held[top];
			if (removed > 0 && total > 0) begin
				res.left = nearest_div(sums[0], total);
				res.top = nearest_div(sums[1], total);
				res.right = nearest_div(sums[2], total);
				res.bottom = nearest_div(sums[3], total);
				res.ax = nearest_div(sums[4], total);
				res.ay = nearest_div(sums[5], total);
				res.bx = nearest_div(sums[6], total);
				res.by = nearest_div(sums[7], total);
			end
			m.d = res;
			m.fin = 1'b0;
			expected.insert(expected.size(), m);
			emitted++;
			if (removed == 0)
				break;
		end
		expected[expected.size() - 1].fin = 1'b1;
	endtask

	task automatic take_request(request_t q);
		if (loaded < 64)
			held[loaded] = q.d;
		if (loaded < 64)
			loaded++;
		if (q.last) begin
			merge_set();
			loaded = 0;
		end
	endtask

	// driver: advance on each accepted request
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			bus <= '0;
			set_end <= 1'b0;
		end else begin
			if (start && !busy)
				take_request(staged);
			if (!start || !busy) begin
				if (pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
					staged = pending.pop_front();
					bus <= staged.d;
					set_end <= staged.last;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(string name, logic [15:0] exp, logic [15:0] act);
		if (exp !== act) begin
			$error("%s: expected %h, got %h", name, exp, act);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		merged_t m;
		if (arst_n && done) begin
			if (expected.size() == 0) begin
				$error("result with none expected");
				mismatches++;
			end else begin
				m = expected.pop_front();
				check_field("out_left", m.d.left, seen.left);
				check_field("out_top", m.d.top, seen.top);
				check_field("out_right", m.d.right, seen.right);
				check_field("out_bottom", m.d.bottom, seen.bottom);
				check_field("out_score", m.d.score, seen.score);
				check_field("out_point_a_x", m.d.ax, seen.ax);
				check_field("out_point_a_y", m.d.ay, seen.ay);
				check_field("out_point_b_x", m.d.bx, seen.bx);
				check_field("out_point_b_y", m.d.by, seen.by);
				check_field("final_result", 16'(m.fin), 16'(final_result));
			end
		end
	end

	function automatic void add_det(int l, int t, int r, int b, int s, bit last);
		request_t q;
		q.d.left = 16'(l);
		q.d.top = 16'(t);
		q.d.right = 16'(r);
		q.d.bottom = 16'(b);
		q.d.score = 16'(s);
		q.d.ax = 16'($urandom);
		q.d.ay = 16'($urandom);
		q.d.bx = 16'($urandom);
		q.d.by = 16'($urandom);
		q.last = last;
		pending.insert(pending.size(), q);
	endfunction

	function automatic int clamp16(int v);
		return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
	endfunction

	// a set of jittered boxes around a few centers, or pure noise
	function automatic int add_set(int n);
		int cl, cs, w, h, l, t, jw, jh, s;
		bit noise;
		noise = ($urandom_range(99) < 15);
		cl = -16000 + $urandom_range(24000);
		cs = -16000 + $urandom_range(24000);
		w = $urandom_range(8000, 100);
		h = $urandom_range(8000, 100);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(3) == 0) begin
				cl = -16000 + $urandom_range(24000);
				cs = -16000 + $urandom_range(24000);
			end
			jw = w / 8 + 1;
			jh = h / 8 + 1;
			l = cl + $urandom_range(2 * jw) - jw;
			t = cs + $urandom_range(2 * jh) - jh;
			case ($urandom_range(9))
				0: s = 0;
				1: s = 65535;
				2: s = 40000;
				default: s = $urandom_range(65535);
			endcase
			if (noise)
				add_det($urandom, $urandom, $urandom, $urandom, $urandom, i == n - 1);
			else
				add_det(l, t, clamp16(l + w + $urandom_range(jw)),
					clamp16(t + h + $urandom_range(jh)), s, i == n - 1);
		end
		return n;
	endfunction

	task automatic drain();
		while (pending.size() > 0 || start || busy || expected.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_threshold(logic [15:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		thr = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_sets(int count);
		int sent, n;
		sent = 0;
		while (sent < count) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(16, 9) : $urandom_range(8, 1);
			sent += add_set(n);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		thr = THR_RESET;
		idle_pct = 25;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// single detection at the extremes
		add_det(-32768, -32768, 32767, 32767, 65535, 1);
		// identical boxes with tied scores
		add_det(0, 0, 4000, 4000, 1000, 0);
		add_det(0, 0, 4000, 4000, 1000, 0);
		add_det(100, 100, 4100, 4100, 0, 1);
		// zero-area and inverted boxes
		add_det(500, 500, 500, 900, 300, 0);
		add_det(500, 500, 500, 900, 200, 0);
		add_det(900, 900, 100, 100, 100, 1);
		// every overlapping score zero
		add_det(-2000, -2000, 2000, 2000, 0, 0);
		add_det(-1900, -1900, 2100, 2100, 0, 1);
		// disjoint boxes, and a chain of merges
		add_det(-30000, -30000, -20000, -20000, 5, 0);
		add_det(20000, 20000, 30000, 30000, 9, 0);
		add_det(0, 0, 1, 1, 7, 0);
		add_det(-32768, 32767, 32767, -32768, 65535, 0);
		add_det(10, 10, 3000, 3000, 60000, 0);
		add_det(20, 20, 3010, 3010, 59999, 0);
		add_det(5000, 5000, 8000, 8000, 1, 1);
		drain();

		write_threshold(16'h0000);
		random_sets(40);
		drain();

		idle_pct = 87;
		write_threshold(16'hFFFF);
		random_sets(50);
		drain();
		write_threshold(16'd32768);
		random_sets(50);
		drain();

		idle_pct = 0;
		write_threshold(16'($urandom));
		void'(add_set(64));
		drain();
		write_threshold(THR_RESET);
		// overflow: the tail of the set is dropped
		void'(add_set(70));
		random_sets(40);
		drain();

		if (mismatches == 0 && expected.size() == 0)
			$display("[weighted_box_suppression] OK");
		else
			$display("[weighted_box_suppression] ERROR");
		$finish;
	end

	initial begin
		#20000000;
		$display("[weighted_box_suppression] ERROR");
		$finish;
	end

endmodule
